FILE: rtl/lrs_pkg.sv
// Shared types, constants and small functions of the LED ring status frame generator.
// No dependencies; every other file of the block imports this package.
package lrs_pkg;

  // Ring geometry and sine table size.
  localparam int LED_COUNT       = 16;
  localparam int LED_CNT_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_INDEX_W     = 4;
  localparam int SINE_TABLE_SIZE = 256;
  localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  ACCENT_RED_RST   = 8'd0;
  localparam logic [7:0]  ACCENT_GREEN_RST = 8'd180;
  localparam logic [7:0]  ACCENT_BLUE_RST  = 8'd255;
  localparam logic [7:0]  FRAME_PERIOD_RST = 8'd20;
  localparam logic [15:0] VOLUME_HOLD_RST  = 16'd2000;
  localparam logic [7:0]  VOLUME_LEVEL_RST = 8'd50;

  // Lit gauge LEDs: floor(level * LED_COUNT / 100) through a 16-bit reciprocal.
  localparam int LIT_FRAC_W = 16;
  localparam int LIT_MUL    = (LED_COUNT * (1 << LIT_FRAC_W) + 99) / 100;
  localparam int LIT_W      = 8;
  localparam int LIT_PROD_W = 8 + LIT_FRAC_W + 1;

  // Breathing pattern: phase step per frame and channel scale factors (Q10).
  localparam logic [15:0] BREATH_STEP = 16'd313;
  localparam int SCALE_FRAC_W = 10;
  localparam int RED_MUL      = 410;   // 2/5
  localparam int BLUE_MUL     = 922;   // 9/10
  localparam int BR_W         = 7;
  localparam int SCALE_PROD_W = BR_W + 11;

  // Request codes of the input word.
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_VOLUME  = 2'd1,
    REQ_MEETING = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_MODE = 3'd0,
    CFG_ACCENT_RED   = 3'd1,
    CFG_ACCENT_GREEN = 3'd2,
    CFG_ACCENT_BLUE  = 3'd3,
    CFG_FRAME_PERIOD = 3'd4,
    CFG_VOLUME_HOLD  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t COL_GAUGE  = '{red: 8'd0,   green: 8'd200, blue: 8'd255};
  localparam rgb_t COL_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam rgb_t COL_HAND   = '{red: 8'd255, green: 8'd200, blue: 8'd0};
  localparam rgb_t COL_MUTED  = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
  localparam rgb_t COL_LIVE   = '{red: 8'd0,   green: 8'd255, blue: 8'd50};

  // One frame as handed from the state logic to the LED sweep.
  typedef struct packed {
    logic             gauge;
    logic [LIT_W-1:0] lit;
    rgb_t             color;
  } frame_desc_t;

  typedef struct packed {
    logic        valid;
    frame_desc_t desc;
  } frame_req_t;

  // floor(35*sin(2*pi*r/256)) for r = 0..64.
  localparam logic [5:0] QSINE [0:64] = '{
    6'd0,  6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd10, 6'd11, 6'd12,
    6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd17, 6'd18,
    6'd19, 6'd20, 6'd20, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
    6'd24, 6'd25, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd28,
    6'd29, 6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31,
    6'd32, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33, 6'd34,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34,
    6'd35
  };

  // Breathing brightness 45 + floor(35*sin) for a position of 256 per turn.
  function automatic logic [BR_W-1:0] breath_level(input logic [7:0] pos);
    logic [6:0] fwd;
    logic [6:0] rev;
    logic [BR_W-1:0] lvl;
    fwd = {1'b0, pos[5:0]};
    rev = 7'd64 - fwd;
    case (pos[7:6])
      2'd0: lvl = 7'd45 + 7'(QSINE[fwd]);
      2'd1: lvl = 7'd45 + 7'(QSINE[rev]);
      2'd2: lvl = (pos[5:0] == 6'd0) ? 7'd45 : 7'd44 - 7'(QSINE[fwd]);
      default: lvl = (pos[5:0] == 6'd0) ? 7'd10 : 7'd44 - 7'(QSINE[rev]);
    endcase
    return lvl;
  endfunction

endpackage

FILE: rtl/lrs_in_if.sv
// Input channel of the LED ring status frame generator: handshake and request word.
// Depends on lrs_pkg.
interface lrs_in_if import lrs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] vol_percent;
  logic       meeting_flag;
  logic       is_muted;
  logic       hand_up;

  modport source (output valid, req_type, vol_percent, meeting_flag, is_muted, hand_up,
                  input ready);
  modport sink (input valid, req_type, vol_percent, meeting_flag, is_muted, hand_up,
                output ready);
endinterface

FILE: rtl/lrs_out_if.sv
// Result channel of the LED ring status frame generator: one LED color per word.
// Depends on lrs_pkg.
interface lrs_out_if import lrs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LED_INDEX_W-1:0] led_index;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   last_led;

  modport source (output valid, led_index, red, green, blue, last_led, input ready);
  modport sink (input valid, led_index, red, green, blue, last_led, output ready);
endinterface

FILE: rtl/lrs_ctrl.sv
// Configuration registers, status state and per-frame color choice.
// Depends on lrs_pkg and lrs_in_if; feeds a frame request to lrs_emit.
module lrs_ctrl import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lrs_in_if.sink                in_ch,
  input  logic                  frame_busy,
  output frame_req_t            frame_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic        display_mode_r;
  logic [7:0]  accent_red_r;
  logic [7:0]  accent_green_r;
  logic [7:0]  accent_blue_r;
  logic [7:0]  frame_period_r;
  logic [15:0] volume_hold_r;

  // Status state and next values.
  logic [7:0]  tick_count_r, tick_count_nxt;
  logic [15:0] volume_remain_r, volume_remain_nxt;
  logic [7:0]  volume_level_r, volume_level_nxt;
  logic        meeting_on_r, meeting_on_nxt;
  logic        meeting_muted_r, meeting_muted_nxt;
  logic        meeting_hand_r, meeting_hand_nxt;
  logic [15:0] breath_phase_r, breath_phase_nxt;

  logic                    accept;
  logic [7:0]              tick_inc;
  logic [7:0]              period;
  logic [15:0]             remain_dec;
  logic [15:0]             phase_step;
  logic [SINE_IDX_W-1:0]   sine_k;
  logic [SINE_IDX_W+7:0]   sine_pos;
  logic [BR_W-1:0]         br;
  logic [SCALE_PROD_W-1:0] red_prod;
  logic [SCALE_PROD_W-1:0] blue_prod;
  logic [LIT_PROD_W-1:0]   lit_prod;
  frame_req_t              req_nxt;

  // A new word is taken whenever the LED sweep holds no pending frame.
  assign in_ch.ready = !frame_busy;
  assign accept      = in_ch.valid && !frame_busy;

  // Values of a tick, shared by the frame decision and the color choice.
  assign tick_inc   = tick_count_r + 8'd1;
  assign period     = (frame_period_r == 8'd0) ? 8'd1 : frame_period_r;
  assign remain_dec = (volume_remain_r != 16'd0) ? volume_remain_r - 16'd1 : 16'd0;
  assign phase_step = breath_phase_r + BREATH_STEP;
  // Table index from the top phase bits, rescaled to 256 positions per turn.
  assign sine_k     = phase_step[15 -: SINE_IDX_W];
  assign sine_pos   = {sine_k, 8'd0} >> SINE_IDX_W;
  assign br         = breath_level(sine_pos[7:0]);
  assign red_prod   = SCALE_PROD_W'(br) * SCALE_PROD_W'(RED_MUL);
  assign blue_prod  = SCALE_PROD_W'(br) * SCALE_PROD_W'(BLUE_MUL);
  assign lit_prod   = LIT_PROD_W'(volume_level_r) * LIT_PROD_W'(LIT_MUL);

  // Request decode and state update.
  always_comb begin
    tick_count_nxt    = tick_count_r;
    volume_remain_nxt = volume_remain_r;
    volume_level_nxt  = volume_level_r;
    meeting_on_nxt    = meeting_on_r;
    meeting_muted_nxt = meeting_muted_r;
    meeting_hand_nxt  = meeting_hand_r;
    breath_phase_nxt  = breath_phase_r;
    req_nxt           = '0;
    if (accept) begin
      case (req_e'(in_ch.req_type))
        REQ_VOLUME: begin
          volume_level_nxt  = in_ch.vol_percent;
          volume_remain_nxt = volume_hold_r;
        end
        REQ_MEETING: begin
          meeting_on_nxt    = in_ch.meeting_flag;
          meeting_muted_nxt = in_ch.is_muted;
          meeting_hand_nxt  = in_ch.hand_up;
        end
        REQ_TICK: begin
          volume_remain_nxt = remain_dec;
          tick_count_nxt    = tick_inc;
          if (tick_inc >= period) begin
            tick_count_nxt = 8'd0;
            req_nxt.valid  = 1'b1;
            // Highest priority first: gauge, meeting, accent, breathing.
            if (remain_dec != 16'd0) begin
              req_nxt.desc.gauge = 1'b1;
              req_nxt.desc.lit   = lit_prod[LIT_FRAC_W +: LIT_W];
              req_nxt.desc.color = COL_GAUGE;
            end else if (meeting_on_r) begin
              if (meeting_hand_r) begin
                req_nxt.desc.color = COL_HAND;
              end else if (meeting_muted_r) begin
                req_nxt.desc.color = COL_MUTED;
              end else begin
                req_nxt.desc.color = COL_LIVE;
              end
            end else if (display_mode_r) begin
              req_nxt.desc.color = '{red: accent_red_r, green: accent_green_r,
                                     blue: accent_blue_r};
            end else begin
              breath_phase_nxt         = phase_step;
              req_nxt.desc.color.red   = red_prod[SCALE_FRAC_W +: 8];
              req_nxt.desc.color.green = 8'd0;
              req_nxt.desc.color.blue  = blue_prod[SCALE_FRAC_W +: 8];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign frame_req = req_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= 1'b0;
      accent_red_r   <= ACCENT_RED_RST;
      accent_green_r <= ACCENT_GREEN_RST;
      accent_blue_r  <= ACCENT_BLUE_RST;
      frame_period_r <= FRAME_PERIOD_RST;
      volume_hold_r  <= VOLUME_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_idx))
        CFG_DISPLAY_MODE: display_mode_r <= cfg_wdata[0];
        CFG_ACCENT_RED:   accent_red_r   <= cfg_wdata[7:0];
        CFG_ACCENT_GREEN: accent_green_r <= cfg_wdata[7:0];
        CFG_ACCENT_BLUE:  accent_blue_r  <= cfg_wdata[7:0];
        CFG_FRAME_PERIOD: frame_period_r <= cfg_wdata[7:0];
        CFG_VOLUME_HOLD:  volume_hold_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Status state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= 8'd0;
      volume_remain_r <= 16'd0;
      volume_level_r  <= VOLUME_LEVEL_RST;
      meeting_on_r    <= 1'b0;
      meeting_muted_r <= 1'b1;
      meeting_hand_r  <= 1'b0;
      breath_phase_r  <= 16'd0;
    end else begin
      tick_count_r    <= tick_count_nxt;
      volume_remain_r <= volume_remain_nxt;
      volume_level_r  <= volume_level_nxt;
      meeting_on_r    <= meeting_on_nxt;
      meeting_muted_r <= meeting_muted_nxt;
      meeting_hand_r  <= meeting_hand_nxt;
      breath_phase_r  <= breath_phase_nxt;
    end
  end

endmodule

FILE: rtl/lrs_emit.sv
// LED sweep: holds one frame and sends its colors one word per LED.
// Depends on lrs_pkg and lrs_out_if; takes frame requests from lrs_ctrl.
module lrs_emit import lrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_req_t frame_req,
  output logic       frame_busy,
  lrs_out_if.source  out_ch
);

  logic                 desc_valid_r, desc_valid_nxt;
  frame_desc_t          desc_r;
  logic [LED_CNT_W-1:0] led_cnt_r, led_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LED_CNT_W-1:0] out_led_r;
  rgb_t                 out_color_r;
  logic                 out_last_r;

  logic load;
  logic last;
  logic lit_on;
  rgb_t color;

  assign frame_busy = desc_valid_r;

  // Color of the LED at the sweep position.
  assign last   = (led_cnt_r == LED_CNT_W'(LED_COUNT - 1));
  assign lit_on = (LIT_W'(led_cnt_r) < desc_r.lit);
  always_comb begin
    if (desc_r.gauge) begin
      color = lit_on ? COL_GAUGE : COL_OFF;
    end else begin
      color = desc_r.color;
    end
  end

  // The output register takes the next LED when it is empty or being drained.
  assign load = desc_valid_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    desc_valid_nxt = desc_valid_r;
    led_cnt_nxt    = led_cnt_r;
    if (load) begin
      if (last) begin
        desc_valid_nxt = 1'b0;
        led_cnt_nxt    = '0;
      end else begin
        led_cnt_nxt = led_cnt_r + LED_CNT_W'(1);
      end
    end
    if (frame_req.valid) begin
      desc_valid_nxt = 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      led_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      led_cnt_r    <= led_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (frame_req.valid) begin
      desc_r <= frame_req.desc;
    end
    if (load) begin
      out_led_r   <= led_cnt_r;
      out_color_r <= color;
      out_last_r  <= last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_index = LED_INDEX_W'(out_led_r);
  assign out_ch.red       = out_color_r.red;
  assign out_ch.green     = out_color_r.green;
  assign out_ch.blue      = out_color_r.blue;
  assign out_ch.last_led  = out_last_r;

  // A new frame only arrives while no frame is held.
  a_req_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    frame_req.valid |-> !desc_valid_r)
    else $error("frame request while a frame is still held");

  // The sweep position leaves zero only inside a held frame.
  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (led_cnt_r != '0) |-> desc_valid_r)
    else $error("LED position moved without a frame");

  // The word sent for the final LED carries the last mark, and only it.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_last_r == (out_led_r == LED_CNT_W'(LED_COUNT - 1))))
    else $error("last mark does not match the LED position");

endmodule

FILE: rtl/led_ring_status_frame_generator_top.sv
// Top level of the LED ring status frame generator.
// Depends on lrs_pkg, lrs_in_if, lrs_out_if, lrs_ctrl and lrs_emit.
//
// Each request word updates the status state as soon as it is taken;
// volume and meeting words and ticks that end no frame give no result. A tick
// that ends a frame latches the chosen color set into the LED sweep, which sends
// one word per LED (16 words, the last one marked) at one word per cycle while
// the result side takes them. The sweep holds one frame, so the next request word
// is taken in the cycle after the frame's last word has entered the output
// register: a frame tick holds the input while the sweep runs, and longer while
// the result side stalls a full output register; every other word leaves the
// input ready for the next word. Configuration writes take effect on
// the next clock edge and should be made while no frame is in flight.
module led_ring_status_frame_generator_top import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lrs_in_if.sink                in_ch,
  lrs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  frame_req_t frame_req;
  logic       frame_busy;

  lrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .frame_busy (frame_busy),
    .frame_req  (frame_req),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  lrs_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_req  (frame_req),
    .frame_busy (frame_busy),
    .out_ch     (out_ch)
  );

endmodule
